// File: rtl/core/mandelbrot_escape_time_macros.svh
// ----------------------------------------------------------------------------
// Mandelbrot escape time macros
// Assertion shorthands shared by the escape-time block.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// Same-cycle implication, checked out of reset only.
`define MBE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset only.
`define MBE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/mbe_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape time package
// Types, constants and register codes shared by the escape-time block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbe_pkg;

	localparam int GRID_SIZE = 4096;
	localparam int FRAC_BITS = 28;
	localparam int IDX_W     = 12;
	localparam int MUL_W     = 32;
	localparam int PROD_W    = 2 * MUL_W;
	// Orbit values stay well inside this width until escape is seen.
	localparam int Z_W       = 48;
	localparam int CNT_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(GRID_SIZE - 1);

	// 2.0 in orbit format, and 4.0 at the scale of an exact square.
	localparam logic signed [Z_W-1:0]    Z_TWO      = Z_W'(64'd2 << FRAC_BITS);
	localparam logic signed [PROD_W-1:0] ESC_THRESH = PROD_W'(64'd1 << (2 * FRAC_BITS + 2));

	localparam logic [CFG_IDX_W-1:0] REG_REAL_ORIGIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAG_ORIGIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT  = 3'd4;

	localparam logic signed [31:0] RST_REAL_ORIGIN = -32'sd536870912;
	localparam logic signed [31:0] RST_IMAG_ORIGIN = -32'sd402653184;
	localparam logic [30:0]        RST_REAL_STEP   = 31'd196608;
	localparam logic [30:0]        RST_IMAG_STEP   = 31'd196608;
	localparam logic [CNT_W-1:0]   RST_ITER_LIMIT  = 16'd1000;

	typedef struct packed {
		logic signed [31:0] real_origin;
		logic signed [31:0] imag_origin;
		logic [30:0]        real_step;
		logic [30:0]        imag_step;
		logic [CNT_W-1:0]   iteration_limit;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP_R,
		ST_MAP_I,
		ST_MAP_C,
		ST_ITER_RR,
		ST_ITER_II,
		ST_ITER_RI,
		ST_ITER_UPD
	} state_t;

endpackage

// File: rtl/core/mbe_cfg_regs.sv
// ----------------------------------------------------------------------------
// Escape time configuration registers
// Holds the view window and the iteration limit, written by index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbe_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mbe_pkg::CFG_DAT_W-1:0]  cfg_data,
	output mbe_pkg::cfg_t                  cfg
);

	mbe_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.real_origin     <= mbe_pkg::RST_REAL_ORIGIN;
			cfg_q.imag_origin     <= mbe_pkg::RST_IMAG_ORIGIN;
			cfg_q.real_step       <= mbe_pkg::RST_REAL_STEP;
			cfg_q.imag_step       <= mbe_pkg::RST_IMAG_STEP;
			cfg_q.iteration_limit <= mbe_pkg::RST_ITER_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				mbe_pkg::REG_REAL_ORIGIN: cfg_q.real_origin     <= $signed(cfg_data);
				mbe_pkg::REG_IMAG_ORIGIN: cfg_q.imag_origin     <= $signed(cfg_data);
				mbe_pkg::REG_REAL_STEP:   cfg_q.real_step       <= cfg_data[30:0];
				mbe_pkg::REG_IMAG_STEP:   cfg_q.imag_step       <= cfg_data[30:0];
				mbe_pkg::REG_ITER_LIMIT:  cfg_q.iteration_limit <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/mbe_mul.sv
// ----------------------------------------------------------------------------
// Escape time shared multiplier
// One signed 32 by 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbe_mul (
	input  logic                                clk,
	input  logic signed [mbe_pkg::MUL_W-1:0]    op_a,
	input  logic signed [mbe_pkg::MUL_W-1:0]    op_b,
	output logic signed [mbe_pkg::PROD_W-1:0]   prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule

// File: rtl/core/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape time
// Maps a pixel to a point c and counts z = z*z + c iterations until escape.
// ----------------------------------------------------------------------------
// A pixel is taken as one transfer of column and row while in_ready is high,
// and its iteration count comes back as one transfer on the output side. The
// block works on one pixel at a time: in_ready stays low from the transfer
// until the count has been handed to the output register, which then holds
// it while the next pixel is already being taken. All work runs through one
// shared signed 32x32 multiplier with a registered product. Mapping the pixel
// to c runs through the states MAP_R, MAP_I and MAP_C after the input
// transfer, and each iteration runs through ITER_RR, ITER_II, ITER_RI and
// ITER_UPD (the real square, the imaginary square, the cross product and
// the update). The orbit ends in ITER_RR when the limit is reached or a
// component is beyond 2.0, or in ITER_RI when the sum of squares ends it,
// and the count is then loaded into the output register from IDLE once that
// register is free or being read. The default iteration limit is 1000.
// The escape test is exact: a component beyond 2.0 escapes at once,
// otherwise the full-width squares are summed and compared with 4.0.
// Configuration registers are written by index with no handshake and should
// only be changed while no pixel is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_macros.svh"

module mandelbrot_escape_time (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write port
	input  logic                           cfg_we,
	input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mbe_pkg::CFG_DAT_W-1:0]  cfg_data,
	// Pixel input channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [mbe_pkg::IDX_W-1:0]      column,
	input  logic [mbe_pkg::IDX_W-1:0]      row,
	// Result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [mbe_pkg::CNT_W-1:0]      iterations
);

	mbe_pkg::cfg_t cfg;

	mbe_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Sequencer state and a flag that the count is final and waits for the
	// output register.
	mbe_pkg::state_t state_q, state_d;
	logic            done_q, done_d;
	logic            out_valid_q;

	// Datapath registers.
	logic [mbe_pkg::IDX_W-1:0]          col_q, row_q;
	logic signed [mbe_pkg::Z_W-1:0]     cr_q, ci_q, zr_q, zi_q;
	logic signed [mbe_pkg::PROD_W-1:0]  rr_q, diff_q;
	logic [mbe_pkg::CNT_W-1:0]          count_q;
	logic [mbe_pkg::CNT_W-1:0]          iterations_q;

	// Shared multiplier.
	logic signed [mbe_pkg::MUL_W-1:0]   op_a, op_b;
	logic signed [mbe_pkg::PROD_W-1:0]  prod_q;

	mbe_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	// Status of the current orbit point.
	logic                               mag_escape;
	logic                               at_limit;
	logic signed [mbe_pkg::PROD_W-1:0]  sq_sum;
	logic                               sq_escape;
	logic                               load_out;

	assign mag_escape = (zr_q > mbe_pkg::Z_TWO) || (zr_q < -mbe_pkg::Z_TWO) ||
		(zi_q > mbe_pkg::Z_TWO) || (zi_q < -mbe_pkg::Z_TWO);
	assign at_limit   = (count_q >= cfg.iteration_limit);
	assign sq_sum     = rr_q + prod_q;
	assign sq_escape  = (sq_sum > mbe_pkg::ESC_THRESH);
	assign load_out   = done_q && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		done_d  = done_q;
		op_a    = '0;
		op_b    = '0;
		case (state_q)
			mbe_pkg::ST_IDLE: begin
				if (done_q) begin
					if (load_out) begin
						done_d = 1'b0;
					end
				end else if (in_valid) begin
					state_d = mbe_pkg::ST_MAP_R;
				end
			end
			mbe_pkg::ST_MAP_R: begin
				op_a    = $signed(mbe_pkg::MUL_W'(col_q));
				op_b    = $signed(mbe_pkg::MUL_W'(cfg.real_step));
				state_d = mbe_pkg::ST_MAP_I;
			end
			mbe_pkg::ST_MAP_I: begin
				op_a    = $signed(mbe_pkg::MUL_W'(row_q));
				op_b    = $signed(mbe_pkg::MUL_W'(cfg.imag_step));
				state_d = mbe_pkg::ST_MAP_C;
			end
			mbe_pkg::ST_MAP_C: begin
				state_d = mbe_pkg::ST_ITER_RR;
			end
			mbe_pkg::ST_ITER_RR: begin
				// Below 2.0 in both parts the low word holds the value exactly.
				op_a = $signed(zr_q[mbe_pkg::MUL_W-1:0]);
				op_b = $signed(zr_q[mbe_pkg::MUL_W-1:0]);
				if (at_limit || mag_escape) begin
					state_d = mbe_pkg::ST_IDLE;
					done_d  = 1'b1;
				end else begin
					state_d = mbe_pkg::ST_ITER_II;
				end
			end
			mbe_pkg::ST_ITER_II: begin
				op_a    = $signed(zi_q[mbe_pkg::MUL_W-1:0]);
				op_b    = $signed(zi_q[mbe_pkg::MUL_W-1:0]);
				state_d = mbe_pkg::ST_ITER_RI;
			end
			mbe_pkg::ST_ITER_RI: begin
				op_a = $signed(zr_q[mbe_pkg::MUL_W-1:0]);
				op_b = $signed(zi_q[mbe_pkg::MUL_W-1:0]);
				if (sq_escape) begin
					state_d = mbe_pkg::ST_IDLE;
					done_d  = 1'b1;
				end else begin
					state_d = mbe_pkg::ST_ITER_UPD;
				end
			end
			mbe_pkg::ST_ITER_UPD: begin
				state_d = mbe_pkg::ST_ITER_RR;
			end
			default: begin
				state_d = mbe_pkg::ST_IDLE;
			end
		endcase
	end

	// A new pixel is taken only while no count is pending, so the output
	// register is never asked to take more than one waiting count.
	assign in_ready = (state_q == mbe_pkg::ST_IDLE) && !done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mbe_pkg::ST_IDLE;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			// Indices past the grid edge are pinned to the last column or row.
			col_q <= ({1'b0, column} >= (mbe_pkg::IDX_W + 1)'(mbe_pkg::GRID_SIZE)) ?
				mbe_pkg::IDX_MAX : column;
			row_q <= ({1'b0, row} >= (mbe_pkg::IDX_W + 1)'(mbe_pkg::GRID_SIZE)) ?
				mbe_pkg::IDX_MAX : row;
		end
		case (state_q)
			mbe_pkg::ST_MAP_I: begin
				cr_q <= mbe_pkg::Z_W'(cfg.real_origin) + prod_q[mbe_pkg::Z_W-1:0];
			end
			mbe_pkg::ST_MAP_C: begin
				ci_q    <= mbe_pkg::Z_W'(cfg.imag_origin) + prod_q[mbe_pkg::Z_W-1:0];
				zr_q    <= '0;
				zi_q    <= '0;
				count_q <= '0;
			end
			mbe_pkg::ST_ITER_II: begin
				rr_q <= prod_q;
			end
			mbe_pkg::ST_ITER_RI: begin
				diff_q <= rr_q - prod_q;
			end
			mbe_pkg::ST_ITER_UPD: begin
				// Floor of the scaled square difference and of twice the cross
				// product, then c is added.
				zr_q <= cr_q + mbe_pkg::Z_W'(diff_q >>> mbe_pkg::FRAC_BITS);
				zi_q <= ci_q + mbe_pkg::Z_W'(prod_q >>> (mbe_pkg::FRAC_BITS - 1));
				count_q <= count_q + 1'b1;
			end
			default: ;
		endcase
		if (load_out) begin
			iterations_q <= count_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign iterations = iterations_q;

	`MBE_ASSERT_NXT(a_start_map, in_valid && in_ready,
		state_q == mbe_pkg::ST_MAP_R, "transfer did not start mapping")
	`MBE_ASSERT_NXT(a_count_step, state_q == mbe_pkg::ST_ITER_UPD,
		count_q == $past(count_q) + 1'b1, "iteration count did not advance")
	`MBE_ASSERT_IMP(a_count_bound, state_q == mbe_pkg::ST_ITER_II ||
		state_q == mbe_pkg::ST_ITER_RI || state_q == mbe_pkg::ST_ITER_UPD,
		count_q < cfg.iteration_limit, "iteration count passed the limit")
	`MBE_ASSERT_IMP(a_mag_bound, state_q == mbe_pkg::ST_ITER_II ||
		state_q == mbe_pkg::ST_ITER_RI, !mag_escape, "squaring an escaped orbit point")

endmodule

// File: sim/mandelbrot_escape_time_test.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape time testbench
// Drives pixels through the escape-time block under several views and
// iteration limits, predicts every iteration count and compares each
// result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandelbrot_escape_time_test;

	// Fixed-point scale and the escape thresholds. A component beyond 2.0
	// escapes at once. Otherwise the exact sum of squares is compared with
	// 4.0, which sits at twice the fraction width plus two bits.
	localparam int                  FRAC        = mbe_pkg::FRAC_BITS;
	localparam logic [63:0]         ESC_TWO     = 64'd2 << FRAC;
	localparam logic signed [127:0] ESC_FOUR    = 128'sd1 <<< (2 * FRAC + 2);
	localparam logic [11:0]         EDGE_HI     = 12'(mbe_pkg::GRID_SIZE - 1);
	// Worst case is far below this: the deepest pixel runs the full limit of
	// 65535 iterations and every other pixel is held to a small limit.
	localparam int                  CYCLE_LIMIT = 4_000_000;
	localparam int                  MAX_REPORTS = 10;
	localparam int                  HOLD_CYCLES = 600;

	typedef struct {
		logic [11:0] col;
		logic [11:0] rw;
		logic [15:0] count;
	} pending_pixel_t;

	// The scoreboard keeps its own copy of the registers, predicts the
	// count of each pixel when its input transfer is seen, and checks the
	// output transfers in order.
	class iteration_scoreboard;
		logic signed [31:0] real_origin;
		logic signed [31:0] imag_origin;
		logic [30:0]        real_step;
		logic [30:0]        imag_step;
		logic [15:0]        iteration_limit;
		pending_pixel_t     expected_counts[$];
		int                 errors;

		function new();
			real_origin     = mbe_pkg::RST_REAL_ORIGIN;
			imag_origin     = mbe_pkg::RST_IMAG_ORIGIN;
			real_step       = mbe_pkg::RST_REAL_STEP;
			imag_step       = mbe_pkg::RST_IMAG_STEP;
			iteration_limit = mbe_pkg::RST_ITER_LIMIT;
			errors          = 0;
		endfunction

		// Indexes past the last register are ignored, as in the block.
		function void write_register(logic [2:0] idx, logic [31:0] data);
			case (idx)
				mbe_pkg::REG_REAL_ORIGIN: real_origin = data;
				mbe_pkg::REG_IMAG_ORIGIN: imag_origin = data;
				mbe_pkg::REG_REAL_STEP:   real_step = data[30:0];
				mbe_pkg::REG_IMAG_STEP:   imag_step = data[30:0];
				mbe_pkg::REG_ITER_LIMIT:  iteration_limit = data[15:0];
				default: ;
			endcase
		endfunction

		// c is formed exactly in 64 bits. The squares and the cross product are exact
		// at 128 bits; their difference and twice the cross product are floored by an
		// arithmetic shift before c is added back in.
		function logic [15:0] predict_iterations(logic [11:0] col, logic [11:0] rw);
			logic signed [63:0]  cr, ci, zr, zi;
			logic signed [127:0] wr, wi, sq_r, sq_i, scaled, twice_ri;
			logic [63:0]         mag_r, mag_i;
			int                  count;
			cr = 64'(real_origin);
			ci = 64'(imag_origin);
			cr = cr + 64'(col) * 64'(real_step);
			ci = ci + 64'(rw) * 64'(imag_step);
			zr = '0;
			zi = '0;
			count = 0;
			while (count < int'(iteration_limit)) begin
				mag_r = zr[63] ? -zr : zr;
				mag_i = zi[63] ? -zi : zi;
				if (mag_r > ESC_TWO || mag_i > ESC_TWO)
					break;
				wr = 128'(zr);
				wi = 128'(zi);
				sq_r = wr * wr;
				sq_i = wi * wi;
				if (sq_r + sq_i > ESC_FOUR)
					break;
				scaled   = (sq_r - sq_i) >>> FRAC;
				twice_ri = (wr * wi) >>> (FRAC - 1);
				zr = scaled[63:0] + cr;
				zi = twice_ri[63:0] + ci;
				count++;
			end
			return 16'(count);
		endfunction

		function void note_pixel(logic [11:0] col, logic [11:0] rw);
			pending_pixel_t p;
			p.col   = col;
			p.rw    = rw;
			p.count = predict_iterations(col, rw);
			expected_counts.push_back(p);
		endfunction

		function void check_count(logic [15:0] actual);
			pending_pixel_t p;
			if (expected_counts.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("ERROR: iteration count %0d arrived with no pixel pending",
						actual);
				return;
			end
			p = expected_counts.pop_front();
			if (actual !== p.count) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("ERROR: pixel (%0d, %0d) expected %0d iterations, got %0d",
						p.col, p.rw, p.count, actual);
			end
		endfunction

		function int outstanding();
			return expected_counts.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data  = '0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [11:0] column    = '0;
	logic [11:0] row       = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] iterations;

	iteration_scoreboard sb = new;

	// Random idling on both sides is on until the last phase of the run.
	bit idle_enable = 1'b1;
	// The main sequence asks for a long hold of the result side by bumping
	// holds_asked; the receiver process counts the hold out itself.
	int holds_asked = 0;
	int cycle_count = 0;

	mandelbrot_escape_time u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.column    (column),
		.row       (row),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.iterations(iterations)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog. A hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Transfers are sampled at the clock edge, before any of this edge's
	// nonblocking updates land, so payload and handshake are the values
	// that were actually presented.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_pixel(column, row);
			if (out_valid && out_ready)
				sb.check_count(iterations);
		end
	end

	// Result receiver. It stalls in random bursts, and once per request it
	// holds off for a long stretch so the block backs up into its input.
	initial begin
		int stall_left;
		int hold_left;
		int holds_done;
		stall_left = 0;
		hold_left  = 0;
		holds_done = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (holds_done != holds_asked) begin
				holds_done++;
				hold_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_enable && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 17) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// One register write, then a quiet cycle so back-to-back writes never
	// lower and raise the write enable in the same time step.
	task automatic set_register(input logic [2:0] idx, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_register(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_view(input logic [31:0] re_org, input logic [31:0] im_org,
		input logic [31:0] re_step, input logic [31:0] im_step, input logic [31:0] limit);
		set_register(mbe_pkg::REG_REAL_ORIGIN, re_org);
		set_register(mbe_pkg::REG_IMAG_ORIGIN, im_org);
		set_register(mbe_pkg::REG_REAL_STEP, re_step);
		set_register(mbe_pkg::REG_IMAG_STEP, im_step);
		set_register(mbe_pkg::REG_ITER_LIMIT, limit);
	endtask

	// Presents one pixel and holds it until the transfer. Valid is only
	// dropped when a gap follows, so a following pixel keeps it high.
	task automatic send_pixel(input logic [11:0] pix_col, input logic [11:0] pix_row);
		column   <= pix_col;
		row      <= pix_row;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (idle_enable && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// Waits for the clock edge first so that the last input transfer has been noted,
	// then until every predicted count has come back.
	task automatic wait_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
		repeat (8) @(posedge clk);
	endtask

	// A random phase picks a view, most of the time one that frames the set
	// so that counts spread over the whole limit, and sometimes a view with
	// every origin and step bit random. Limits stay small to keep the run short.
	task automatic run_random_phase(input int phase, input int items);
		logic [31:0] re_org, im_org, re_step, im_step;
		logic [15:0] limit;
		logic [11:0] pc, pr;
		if (phase % 4 == 3) begin
			re_org  = $urandom;
			im_org  = $urandom;
			re_step = $urandom;
			im_step = $urandom;
		end else begin
			re_org  = 32'(-671088640 + int'($urandom_range(0, 32'h3000_0000)));
			im_org  = 32'(-402653184 + int'($urandom_range(0, 32'h1000_0000)));
			// Bit 31 of a step write has no register bit behind it.
			re_step = {1'($urandom_range(0, 1)), 31'($urandom_range(1, 1 << 18))};
			im_step = {1'($urandom_range(0, 1)), 31'($urandom_range(1, 1 << 18))};
		end
		limit = (phase == 5) ? 16'd250 : 16'($urandom_range(1, 64));
		set_view(re_org, im_org, re_step, im_step, {16'($urandom), limit});
		// The pressure phase starts with a long receiver hold.
		if (phase == 2)
			holds_asked++;
		repeat (items) begin
			pc = 12'($urandom_range(0, 4095));
			pr = 12'($urandom_range(0, 4095));
			// A share of pixels sit on the grid corners.
			if ($urandom_range(0, 6) == 0)
				pc = $urandom_range(0, 1) ? EDGE_HI : '0;
			if ($urandom_range(0, 6) == 0)
				pr = $urandom_range(0, 1) ? EDGE_HI : '0;
			send_pixel(pc, pr);
		end
		wait_until_drained();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset view: real -2.0 to about 1.0, imaginary -1.5 to about 1.5, limit
		// 1000. The corners escape fast; the pixel near c = 0 and the pixel
		// at c = -2 both stay in. At c = -2 the orbit settles on 2.0, where
		// the sum of squares equals 4 exactly and must not count as escape.
		send_pixel('0, '0);
		send_pixel(EDGE_HI, EDGE_HI);
		send_pixel('0, EDGE_HI);
		send_pixel(EDGE_HI, '0);
		send_pixel(12'd2731, 12'd2048);
		send_pixel('0, 12'd2048);
		send_pixel(12'd2048, 12'd2048);
		wait_until_drained();

		// A limit of zero gives zero iterations. The written value only has
		// bits above the sixteen that the register keeps.
		set_register(mbe_pkg::REG_ITER_LIMIT, 32'h0001_0000);
		send_pixel(12'd2731, 12'd2048);
		send_pixel('0, '0);
		wait_until_drained();

		// A limit of one: every pixel does its first step from z = 0.
		set_register(mbe_pkg::REG_ITER_LIMIT, 32'd1);
		send_pixel(12'd2731, 12'd2048);
		send_pixel(EDGE_HI, EDGE_HI);
		wait_until_drained();

		// Extreme registers: largest origins of both signs, full steps
		// written with bit 31 set, and the largest limit. c lands far out.
		set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF);
		send_pixel('0, '0);
		send_pixel(EDGE_HI, EDGE_HI);
		send_pixel(EDGE_HI, '0);
		send_pixel('0, EDGE_HI);
		wait_until_drained();
		set_view(32'h8000_0000, 32'h7FFF_FFFF, '0, '0, 32'h0000_FFFF);
		send_pixel(EDGE_HI, 12'd1365);
		wait_until_drained();

		// Writes to the unused indexes must leave every register alone. The
		// view that follows puts c at zero, which runs the full limit.
		set_view('0, '0, '0, '0, 32'h0000_FFFF);
		for (int k = int'(mbe_pkg::REG_ITER_LIMIT) + 1; k < (1 << mbe_pkg::CFG_IDX_W); k++)
			set_register(3'(k), $urandom);
		send_pixel(12'd1234, 12'd3000);
		wait_until_drained();

		// Random phases, the last one with no idling on either side.
		for (int phase = 0; phase < 8; phase++) begin
			if (phase == 7)
				idle_enable = 1'b0;
			run_random_phase(phase, 75);
		end

		repeat (100) @(posedge clk);
		if (sb.outstanding() != 0) begin
			sb.errors += sb.outstanding();
			$display("ERROR: %0d predicted counts never arrived", sb.outstanding());
		end
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/mbe_pkg.sv
rtl/core/mbe_cfg_regs.sv
rtl/core/mbe_mul.sv
rtl/core/mandelbrot_escape_time.sv
sim/mandelbrot_escape_time_test.sv
